/* rtl/ghnr_pkg.sv */
// Package for the gamepad handshake nibble responder.
// Holds the beat payload structs, the phase enum and the fixed nibble codes.
// No dependencies.
package ghnr_pkg;

    // One input beat: sampled pin levels and button levels
    typedef struct packed {
        logic       select_n;
        logic       request;
        logic [3:0] directions;
        logic [2:0] kick_buttons;
        logic       start_button;
        logic [2:0] punch_buttons;
        logic       shoulder_right;
        logic       shoulder_left;
    } ghnr_in_t;

    // One result beat: data lines and acknowledge level
    typedef struct packed {
        logic [3:0] data_nibble;
        logic       acknowledge;
    } ghnr_out_t;

    // Handshake phases; codes 10..15 are unused
    typedef enum logic [3:0] {
        PH_IDLE_SYNC = 4'd0,
        PH_SEL_LOW   = 4'd1,
        PH_REQ_LOW   = 4'd2,
        PH_SIZE      = 4'd3,
        PH_DIRS      = 4'd4,
        PH_KICK      = 4'd5,
        PH_PUNCH     = 4'd6,
        PH_ONES      = 4'd7,
        PH_END0      = 4'd8,
        PH_END1      = 4'd9
    } ghnr_phase_t;

    localparam logic [3:0] NIB_ID      = 4'h0;
    localparam logic [3:0] NIB_SIZE    = 4'h2;
    localparam logic [2:0] NIB_ONES_LO = 3'h7;
    localparam logic [3:0] NIB_END0    = 4'h0;
    localparam logic [3:0] NIB_END1    = 4'h1;
    localparam logic [3:0] NIB_RESET   = 4'h1;
    localparam logic       ACK_RESET   = 1'b1;

endpackage

/* rtl/ghnr_fsm.sv */
// Phase sequencer of the gamepad handshake nibble responder.
// Holds phase, nibble and acknowledge state; one transition per stepped beat.
// Depends on ghnr_pkg.
module ghnr_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  ghnr_pkg::ghnr_in_t item,
    input  logic              extra_buttons_on,
    output ghnr_pkg::ghnr_out_t result
);
    import ghnr_pkg::*;

    ghnr_phase_t phase_reg, phase_next;
    logic [3:0]  nibble_reg, nibble_next;
    logic        ack_reg, ack_next;

    logic sel_high, req_high, go_high, go_low;
    logic rbit, lbit;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE_SYNC;
            nibble_reg <= NIB_RESET;
            ack_reg    <= ACK_RESET;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            ack_reg    <= ack_next;
        end
    end

    // Next phase and line levels
    always_comb begin
        sel_high    = item.select_n;
        req_high    = item.request;
        go_high     = req_high | sel_high;
        go_low      = ~req_high | sel_high;
        rbit        = extra_buttons_on ? item.shoulder_right : 1'b1;
        lbit        = extra_buttons_on ? item.shoulder_left  : 1'b1;
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        ack_next    = ack_reg;
        unique case (phase_reg)
            PH_IDLE_SYNC: begin
                if (sel_high && req_high) phase_next = PH_SEL_LOW;
            end
            PH_SEL_LOW: begin
                if (!sel_high) phase_next = PH_REQ_LOW;
            end
            PH_REQ_LOW: begin
                if (!req_high) begin
                    nibble_next = NIB_ID;
                    ack_next    = 1'b0;
                    phase_next  = PH_SIZE;
                end
            end
            PH_SIZE: begin
                if (go_high) begin
                    nibble_next = NIB_SIZE;
                    ack_next    = 1'b1;
                    phase_next  = PH_DIRS;
                end
            end
            PH_DIRS: begin
                if (go_low) begin
                    nibble_next = item.directions;
                    ack_next    = 1'b0;
                    phase_next  = PH_KICK;
                end
            end
            PH_KICK: begin
                if (go_high) begin
                    nibble_next = {item.start_button, item.kick_buttons};
                    ack_next    = 1'b1;
                    phase_next  = PH_PUNCH;
                end
            end
            PH_PUNCH: begin
                if (go_low) begin
                    nibble_next = {rbit, item.punch_buttons};
                    ack_next    = 1'b0;
                    phase_next  = PH_ONES;
                end
            end
            PH_ONES: begin
                if (go_high) begin
                    nibble_next = {lbit, NIB_ONES_LO};
                    ack_next    = 1'b1;
                    phase_next  = PH_END0;
                end
            end
            PH_END0: begin
                if (go_low) begin
                    nibble_next = NIB_END0;
                    ack_next    = 1'b0;
                    phase_next  = PH_END1;
                end
            end
            PH_END1: begin
                if (go_high) begin
                    nibble_next = NIB_END1;
                    ack_next    = 1'b1;
                    phase_next  = PH_IDLE_SYNC;
                end
            end
            default: begin
                // unused code: back to idle sync, lines hold
                phase_next = PH_IDLE_SYNC;
            end
        endcase
        result.data_nibble = nibble_next;
        result.acknowledge = ack_next;
    end

endmodule

/* rtl/gamepad_handshake_nibble_responder.sv */
// Top level of the gamepad handshake nibble responder.
// Input beat register, phase sequencer and result register.
// Depends on ghnr_pkg and ghnr_fsm.
//
// Usage:
//   Each input beat on s_valid/s_ready carries one tick's sample of the
//   select and request lines plus the button levels. For every input beat
//   the block returns exactly one result beat on m_valid/m_ready with the
//   data nibble and acknowledge level to drive after that tick.
//   m_valid rises once an accepted input beat has passed the input register,
//   then the result register; a beat waits in the input register while the
//   result register holds one not yet taken. Throughput is one beat per cycle
//   while m_ready is high; the phase sequencer takes one transition per beat.
//   cfg_wr_en writes extra_buttons_on from cfg_wr_data at once; write it
//   only while no beat is in flight.
//   Reset (aresetn low, synchronous) empties both registers, puts the
//   sequencer into idle sync with nibble 1 and acknowledge high, and
//   clears extra_buttons_on.
//   When the receiver stalls, the result register holds its beat and the
//   input register still takes one more beat; further beats then wait.
module gamepad_handshake_nibble_responder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ghnr_pkg::ghnr_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ghnr_pkg::ghnr_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data
);
    import ghnr_pkg::*;

    logic      in_valid_reg;
    ghnr_in_t  in_data_reg;
    logic      out_valid_reg;
    ghnr_out_t out_data_reg;
    logic      extra_buttons_reg;
    logic      advance;
    ghnr_out_t step_result;

    // Move a beat from the input register into the result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extra_buttons_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            extra_buttons_reg <= cfg_wr_data;
        end
    end

    // Input beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    // Phase sequencer
    ghnr_fsm u_fsm (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (advance),
        .item             (in_data_reg),
        .extra_buttons_on (extra_buttons_reg),
        .result           (step_result)
    );

endmodule
